### design/wsd_pkg.sv
package wsd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned OPCODE_W    = 4;
  localparam int unsigned LIMIT_W     = 24;
  localparam int unsigned EXT_CNT_W   = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'h10_0000;

  localparam logic [6:0]           LEN_EXT16   = 7'd126;
  localparam logic [6:0]           LEN_EXT64   = 7'd127;
  localparam logic [EXT_CNT_W-1:0] EXT16_BYTES = 4'd2;
  localparam logic [EXT_CNT_W-1:0] EXT64_BYTES = 4'd8;

  typedef enum logic [2:0] {
    ST_DATA   = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_NOFIN  = 3'd2,
    ST_MASKED = 3'd3,
    ST_LONG   = 3'd4
  } status_e;

  typedef enum logic {
    CFG_FRAME_LIMIT  = 1'b0,
    CFG_BUFFER_LIMIT = 1'b1
  } cfg_index_e;

  typedef struct packed {
    status_e               status;
    logic [OPCODE_W-1:0]   opcode;
    logic [BYTE_W-1:0]     data_byte;
    logic                  last_byte;
  } result_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

endpackage

### design/wsd_parse.sv
module wsd_parse (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [wsd_pkg::BYTE_W-1:0]   rx_byte_i,
  input  logic [wsd_pkg::LIMIT_W-1:0]  frame_limit_i,
  input  logic [wsd_pkg::LIMIT_W-1:0]  buffer_limit_i,
  output logic                         push_o,
  output wsd_pkg::result_t             push_data_o
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_DATA,
    PH_HALT
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [OPCODE_W-1:0]  opcode_q, opcode_d;
  logic [EXT_CNT_W-1:0] ext_left_q, ext_left_d;
  logic [LIMIT_W-1:0]   len_q, len_d;
  logic                 sticky_q, sticky_d;

  logic [LIMIT_W-1:0]   chk_len;
  logic                 chk_sticky;
  logic                 chk_en;

  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    ext_left_d  = ext_left_q;
    len_d       = len_q;
    sticky_d    = sticky_q;
    chk_en      = 1'b0;
    chk_len     = {{(LIMIT_W-7){1'b0}}, rx_byte_i[6:0]};
    chk_sticky  = 1'b0;
    push_o      = 1'b0;
    push_data_o = '{status: ST_DATA, opcode: opcode_q, data_byte: '0, last_byte: 1'b0};

    if (accept_i) begin
      unique case (phase_q)
        PH_HDR0: begin
          opcode_d = rx_byte_i[OPCODE_W-1:0];
          if (!rx_byte_i[7]) begin
            push_o      = 1'b1;
            push_data_o = '{status: ST_NOFIN, opcode: rx_byte_i[OPCODE_W-1:0],
                            data_byte: '0, last_byte: 1'b0};
            phase_d     = PH_HALT;
          end else begin
            phase_d = PH_HDR1;
          end
        end
        PH_HDR1: begin
          if (rx_byte_i[7]) begin
            push_o             = 1'b1;
            push_data_o.status = ST_MASKED;
            phase_d            = PH_HALT;
          end else if (rx_byte_i[6:0] == LEN_EXT16 || rx_byte_i[6:0] == LEN_EXT64) begin
            ext_left_d = (rx_byte_i[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            len_d      = '0;
            sticky_d   = 1'b0;
            phase_d    = PH_EXT;
          end else begin
            chk_en = 1'b1;
          end
        end
        PH_EXT: begin
          // shift in big-endian; anything pushed out the top makes the frame too long
          len_d      = {len_q[LIMIT_W-BYTE_W-1:0], rx_byte_i};
          sticky_d   = sticky_q | (len_q[LIMIT_W-1:LIMIT_W-BYTE_W] != '0);
          ext_left_d = ext_left_q - EXT_CNT_W'(1);
          chk_len    = len_d;
          chk_sticky = sticky_d;
          chk_en     = (ext_left_q == EXT_CNT_W'(1));
        end
        PH_DATA: begin
          len_d                 = len_q - LIMIT_W'(1);
          push_o                = 1'b1;
          push_data_o.data_byte = rx_byte_i;
          if (len_q == LIMIT_W'(1)) begin
            push_data_o.last_byte = 1'b1;
            phase_d               = PH_HDR0;
          end
        end
        PH_HALT: begin
          // drop everything until reset
        end
        default: phase_d = PH_HALT;
      endcase

      if (chk_en) begin
        priority if (chk_sticky || chk_len > frame_limit_i || chk_len > buffer_limit_i) begin
          push_o             = 1'b1;
          push_data_o.status = ST_LONG;
          phase_d            = PH_HALT;
        end else if (chk_len == '0) begin
          push_o                = 1'b1;
          push_data_o.status    = ST_EMPTY;
          push_data_o.last_byte = 1'b1;
          phase_d               = PH_HDR0;
        end else begin
          len_d   = chk_len;
          phase_d = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      opcode_q   <= '0;
      ext_left_q <= '0;
      len_q      <= '0;
      sticky_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      opcode_q   <= opcode_d;
      ext_left_q <= ext_left_d;
      len_q      <= len_d;
      sticky_q   <= sticky_d;
    end
  end

endmodule

### design/wsd_queue.sv
module wsd_queue #(
  parameter int unsigned Depth = wsd_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wsd_pkg::result_t  push_data_i,
  input  logic              pop_i,
  output wsd_pkg::result_t  head_o,
  output wsd_pkg::q_stat_t  stat_o
);
  import wsd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(Depth - 1)) ? '0 : ptr + PtrW'(1);
  endfunction

  assign head_o          = mem_q[rd_ptr_q];
  assign stat_o.full     = (count_q == CntW'(Depth));
  assign stat_o.nonempty = (count_q != '0);

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### design/wsd_emit.sv
module wsd_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wsd_pkg::q_stat_t  q_stat_i,
  input  wsd_pkg::result_t  head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wsd_pkg::result_t  out_data_o
);
  import wsd_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;
  logic    load;

  // refill the output register whenever it is empty or its transfer completes
  assign load  = !valid_q || out_ready_i;
  assign pop_o = load && q_stat_i.nonempty;

  always_comb begin
    valid_d = load ? q_stat_i.nonempty : valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### design/websocket_server_frame_deframer.sv
// Splits a server-to-client WebSocket byte stream into unmasked frames, one
// byte per cycle in both directions unless stalled: header bytes are
// swallowed, each payload byte leaves with its opcode and a last mark, and a
// zero-length frame leaves as one empty-frame result. The parser decides
// everything for a byte in the cycle it is transferred, so the rate is set by
// that single parse step; a small result queue and an output register behind
// it let the input keep running while the output stalls, and rx_ready_o
// drops only when the queue is full. Frame length is checked against
// frame_limit and buffer_limit at the header. FIN clear, MASK set or an
// over-long frame is reported once, after which input is still taken but
// dropped until reset. Write the limits only while the block is idle.
module websocket_server_frame_deframer #(
  parameter int unsigned QueueDepth = wsd_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [wsd_pkg::LIMIT_W-1:0]  cfg_data_i,
  input  logic                         rx_valid_i,
  output logic                         rx_ready_o,
  input  logic [wsd_pkg::BYTE_W-1:0]   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   status_o,
  output logic [wsd_pkg::OPCODE_W-1:0] opcode_o,
  output logic [wsd_pkg::BYTE_W-1:0]   data_byte_o,
  output logic                         last_byte_o
);
  import wsd_pkg::*;

  logic [LIMIT_W-1:0] frame_limit_q, buffer_limit_q;
  logic               accept;
  logic               push, pop;
  result_t            push_data, head, out_data;
  q_stat_t            q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q  <= LIMIT_RESET;
      buffer_limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_FRAME_LIMIT:  frame_limit_q  <= cfg_data_i;
        CFG_BUFFER_LIMIT: buffer_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rx_ready_o = !q_stat.full;
  assign accept     = rx_valid_i && rx_ready_o;

  wsd_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .rx_byte_i      (rx_byte_i),
    .frame_limit_i  (frame_limit_q),
    .buffer_limit_i (buffer_limit_q),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  wsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  wsd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign status_o    = out_data.status;
  assign opcode_o    = out_data.opcode;
  assign data_byte_o = out_data.data_byte;
  assign last_byte_o = out_data.last_byte;

`ifndef SYNTH
  // a full queue can only build up behind a stalled output register
  a_full_needs_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> out_valid_o)
    else $error("result queue full while output register empty");

  // a byte is refused only while the queue is full behind a held result
  a_refuse_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_valid_i && !rx_ready_o) |-> (q_stat.full && out_valid_o))
    else $error("input refused without output stall");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_DATA && status_o != ST_EMPTY)
      |-> (data_byte_o == '0 && !last_byte_o))
    else $error("error result carries data or last mark");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |-> (last_byte_o && data_byte_o == '0))
    else $error("empty frame result without last mark");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import wsd_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int IDLE_PERCENT   = 30;
  localparam int PHASE_BYTES    = 100;
  localparam int RANDOM_PHASES  = 4;
  localparam int NOISE_BYTES    = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

  // length encodings of the second header byte
  localparam int ENC_SHORT = 0;
  localparam int ENC_16    = 1;
  localparam int ENC_64    = 2;

  // payload fill patterns
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;

  // error that ends the run
  localparam int ERR_NOFIN  = 0;
  localparam int ERR_MASK   = 1;
  localparam int ERR_OVER   = 2;
  localparam int ERR_TOPBIT = 3;

  typedef enum logic [2:0] {
    AWAIT_HDR0,
    AWAIT_LEN,
    EXT_LEN,
    PAYLOAD,
    HALTED
  } parse_e;

  class deframer_scoreboard;
    localparam int MaxPrinted = 20;

    parse_e               state;
    logic [OPCODE_W-1:0]  cur_opcode;
    logic [EXT_CNT_W-1:0] ext_left;
    logic [63:0]          remaining;
    logic [LIMIT_W-1:0]   frame_limit;
    logic [LIMIT_W-1:0]   buffer_limit;
    result_t              pending_results[$];
    int                   errors;
    int                   bytes_in;
    int                   results_out;
    int                   frames_done;

    function new();
      state        = AWAIT_HDR0;
      cur_opcode   = '0;
      ext_left     = '0;
      remaining    = '0;
      frame_limit  = LIMIT_RESET;
      buffer_limit = LIMIT_RESET;
      errors       = 0;
      bytes_in     = 0;
      results_out  = 0;
      frames_done  = 0;
    endfunction

    function void set_limit(cfg_index_e idx, logic [LIMIT_W-1:0] value);
      if (idx == CFG_FRAME_LIMIT) frame_limit = value;
      else buffer_limit = value;
    endfunction

    function void queue_result(status_e st, logic [BYTE_W-1:0] data, logic last);
      result_t r;
      r.status    = st;
      r.opcode    = cur_opcode;
      r.data_byte = data;
      r.last_byte = last;
      pending_results.push_back(r);
      if (last) frames_done++;
    endfunction

    // Length complete: check both limits, then report an empty frame or start the payload.
    function void close_length();
      if (remaining > {40'd0, frame_limit} || remaining > {40'd0, buffer_limit}) begin
        state = HALTED;
        queue_result(ST_LONG, '0, 1'b0);
      end else if (remaining == 0) begin
        state = AWAIT_HDR0;
        queue_result(ST_EMPTY, '0, 1'b1);
      end else begin
        state = PAYLOAD;
      end
    endfunction

    function void parse_byte(logic [BYTE_W-1:0] b);
      bytes_in++;
      case (state)
        AWAIT_HDR0: begin
          cur_opcode = b[OPCODE_W-1:0];
          if (!b[7]) begin
            state = HALTED;
            queue_result(ST_NOFIN, '0, 1'b0);
          end else begin
            state = AWAIT_LEN;
          end
        end
        AWAIT_LEN: begin
          if (b[7]) begin
            state = HALTED;
            queue_result(ST_MASKED, '0, 1'b0);
          end else begin
            remaining = '0;
            if (b[6:0] == LEN_EXT16) begin
              ext_left = EXT16_BYTES;
              state    = EXT_LEN;
            end else if (b[6:0] == LEN_EXT64) begin
              ext_left = EXT64_BYTES;
              state    = EXT_LEN;
            end else begin
              remaining = {57'd0, b[6:0]};
              close_length();
            end
          end
        end
        EXT_LEN: begin
          remaining = {remaining[55:0], b};
          if (ext_left != 0) ext_left--;
          if (ext_left == 0) close_length();
        end
        PAYLOAD: begin
          if (remaining != 0) remaining--;
          if (remaining == 0) begin
            state = AWAIT_HDR0;
            queue_result(ST_DATA, b, 1'b1);
          end else begin
            queue_result(ST_DATA, b, 1'b0);
          end
        end
        default: state = HALTED;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxPrinted) $display("mismatch: %s", msg);
    endtask

    task check_result(logic [2:0] st, logic [OPCODE_W-1:0] opc, logic [BYTE_W-1:0] data,
                      logic last);
      result_t want;
      results_out++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %0d: status %0d opcode %h data %h last %b",
                         results_out, st, opc, data, last));
      end else begin
        want = pending_results.pop_front();
        if (st != want.status)
          report($sformatf("result %0d: status %0d, want %0d", results_out, st, want.status));
        if (opc != want.opcode)
          report($sformatf("result %0d: opcode %h, want %h", results_out, opc, want.opcode));
        if (data != want.data_byte)
          report($sformatf("result %0d: data %h, want %h", results_out, data, want.data_byte));
        if (last != want.last_byte)
          report($sformatf("result %0d: last %b, want %b", results_out, last, want.last_byte));
      end
    endtask

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_index_i;
  logic [LIMIT_W-1:0]  cfg_data_i;
  logic                rx_valid_i;
  logic                rx_ready_o;
  logic [BYTE_W-1:0]   rx_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [2:0]          status_o;
  logic [OPCODE_W-1:0] opcode_o;
  logic [BYTE_W-1:0]   data_byte_o;
  logic                last_byte_o;

  deframer_scoreboard sb;
  bit                 no_idle;
  bit                 hold_req;
  int                 hold_left;
  int                 stall_cycles;
  logic [LIMIT_W-1:0] cap;

  websocket_server_frame_deframer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .opcode_o    (opcode_o),
    .data_byte_o (data_byte_o),
    .last_byte_o (last_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        hold_left   = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Observe transfers on both channels; check results and watch for a hang.
  initial stall_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(status_o, opcode_o, data_byte_o, last_byte_o);
      if (rx_valid_i && rx_ready_o) sb.parse_byte(rx_byte_i);
      if ((out_valid_o && out_ready_i) || (rx_valid_i && rx_ready_o)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", stall_cycles);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [BYTE_W-1:0] b);
    if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      rx_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
  endtask

  task automatic send_frame(logic [OPCODE_W-1:0] opc, logic [63:0] len, int enc, int fill);
    logic [BYTE_W-1:0] b;
    send_byte({1'b1, 3'($urandom_range(7)), opc});
    case (enc)
      ENC_SHORT: send_byte({1'b0, len[6:0]});
      ENC_16: begin
        send_byte({1'b0, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({1'b0, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    for (longint unsigned i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = '0;
        FILL_ONES: b = '1;
        default:   b = 8'($urandom);
      endcase
      send_byte(b);
    end
  endtask

  // Mostly short frames, now and then one up to the tighter limit or 400, whichever is less.
  task automatic random_frame(logic [LIMIT_W-1:0] lim);
    int unsigned pick;
    int unsigned len_max;
    logic [63:0] len;
    int          enc;
    pick    = $urandom_range(99);
    len_max = (lim > 400) ? 400 : lim;
    if (pick < 10) len = '0;
    else if (pick < 80) len = 64'($urandom_range((len_max < 16) ? len_max : 16));
    else if (pick < 95) len = 64'($urandom_range(len_max));
    else len = 64'(len_max);
    if (len > 125) enc = $urandom_range(ENC_16, ENC_64);
    else enc = $urandom_range(ENC_SHORT, ENC_64);
    send_frame(4'($urandom), len, enc, FILL_RANDOM);
  endtask

  // Drop valid and let every owed result leave before touching the limits.
  task automatic drain();
    rx_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_limits(logic [LIMIT_W-1:0] frame_lim, logic [LIMIT_W-1:0] buf_lim);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_FRAME_LIMIT;
    cfg_data_i  <= frame_lim;
    @(posedge clk_i);
    sb.set_limit(CFG_FRAME_LIMIT, frame_lim);
    cfg_index_i <= CFG_BUFFER_LIMIT;
    cfg_data_i  <= buf_lim;
    @(posedge clk_i);
    sb.set_limit(CFG_BUFFER_LIMIT, buf_lim);
    cfg_we_i <= 1'b0;
    cap = (frame_lim < buf_lim) ? frame_lim : buf_lim;
  endtask

  function automatic logic [LIMIT_W-1:0] pick_limit();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return LIMIT_MAX;
    if (pick == 1) return LIMIT_W'($urandom_range(1, 40));
    return LIMIT_W'($urandom_range(40, 3000));
  endfunction

  initial begin
    int    start_bytes;
    int    err;
    string err_name;
    sb          = new();
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    cap         = LIMIT_RESET;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_FRAME_LIMIT;
    cfg_data_i  = '0;
    rx_valid_i  = 1'b0;
    rx_byte_i   = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limits: empty frames in two encodings, short frames of all-zero and all-one
    send_frame(4'hF, 64'd0, ENC_SHORT, FILL_RANDOM);
    send_frame(4'h0, 64'd0, ENC_16, FILL_RANDOM);
    send_frame(4'h9, 64'd1, ENC_SHORT, FILL_ZERO);
    send_frame(4'h1, 64'd2, ENC_64, FILL_ONES);
    drain();

    // zero frame limit: only empty frames get through
    set_limits('0, LIMIT_MAX);
    send_frame(4'h8, 64'd0, ENC_64, FILL_RANDOM);
    repeat (6) random_frame(cap);
    drain();

    // widest limits with no idling: longest short length, shortest 16-bit length,
    // and short frames in the 16-bit and 64-bit forms
    set_limits(LIMIT_MAX, LIMIT_MAX);
    no_idle = 1'b1;
    send_frame(4'h2, 64'd125, ENC_SHORT, FILL_RANDOM);
    send_frame(4'hA, 64'd126, ENC_16, FILL_RANDOM);
    send_frame(4'h1, 64'd3, ENC_16, FILL_RANDOM);
    send_frame(4'h2, 64'd5, ENC_64, FILL_RANDOM);
    drain();
    no_idle = 1'b0;

    // payload exactly at the tighter limit, each register tighter in turn
    set_limits(24'd90, 24'd60);
    send_frame(4'h5, 64'd60, ENC_64, FILL_RANDOM);
    drain();
    set_limits(24'd60, 24'd90);
    send_frame(4'h6, 64'd60, ENC_16, FILL_RANDOM);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_limits(pick_limit(), pick_limit());
      if (p == 1) hold_req = 1'b1;
      start_bytes = sb.bytes_in;
      while (sb.bytes_in - start_bytes < PHASE_BYTES) random_frame(cap);
      drain();
    end

    // One error halts the block for good, so end the run on one picked at random.
    set_limits(LIMIT_W'($urandom_range(1, 300)), LIMIT_W'($urandom_range(1, 300)));
    err = $urandom_range(ERR_NOFIN, ERR_TOPBIT);
    case (err)
      ERR_NOFIN: begin
        err_name = "FIN clear";
        send_byte({1'b0, 7'($urandom)});
      end
      ERR_MASK: begin
        err_name = "MASK set";
        send_byte({1'b1, 7'($urandom)});
        send_byte({1'b1, 7'($urandom)});
      end
      ERR_OVER: begin
        err_name = "length one over limit";
        send_frame(4'($urandom), 64'(cap) + 64'd1,
                   (cap < 125) ? ENC_SHORT : ENC_16, FILL_RANDOM);
      end
      default: begin
        err_name = "64-bit length with top bit set";
        send_byte({1'b1, 3'($urandom_range(7)), 4'($urandom)});
        send_byte({1'b0, LEN_EXT64});
        send_byte(8'h80 | 8'($urandom));
        repeat (7) send_byte(8'($urandom));
      end
    endcase
    // halted: everything after this is dropped
    repeat (NOISE_BYTES) send_byte(8'($urandom));
    drain();

    if (sb.outstanding() != 0) sb.report("results still owed at end of run");
    $display("summary: %0d bytes transferred in, %0d results checked, %0d frames completed",
             sb.bytes_in, sb.results_out, sb.frames_done);
    $display("summary: limits varied from zero to full range, run closed on %s error",
             err_name);
    if (sb.errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
